// File: rtl/rpy_pkg.sv
// ----------------------------------------------------------------------------
// rpy_pkg: shared constants, types and functions for the RGB pair to YUY2
// converter. Holds the BT.601 weights and the divide-by-1000 reciprocal.
// ----------------------------------------------------------------------------
package rpy_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SUM_W  = 18;   // 1000 * 255 fits in 18 bits
  localparam int unsigned WORD_W = 32;

  localparam logic [SUM_W-1:0] LUMA_R_W = 18'd299;
  localparam logic [SUM_W-1:0] LUMA_G_W = 18'd587;
  localparam logic [SUM_W-1:0] LUMA_B_W = 18'd114;
  localparam logic [SUM_W-1:0] CB_GAIN  = 18'd564;
  localparam logic [SUM_W-1:0] CR_GAIN  = 18'd713;

  localparam logic [9:0] CHROMA_BIAS = 10'sd128;
  localparam logic [9:0] CHAN_MAX    = 10'd255;

  // floor(s / 1000) == (s * RECIP_1000) >> RECIP_SHIFT for every s below 2**18:
  // RECIP_1000 = ceil(2**28 / 1000), error term 544 * s stays below 2**28.
  localparam int unsigned RECIP_W     = 19;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 19'd268436;
  localparam int unsigned PROD_W = SUM_W + RECIP_W;

  typedef struct packed {
    logic [CHAN_W-1:0] y0;
    logic [CHAN_W-1:0] y1;
    logic [CHAN_W-1:0] yy;
    logic [CHAN_W-1:0] ra;
    logic [CHAN_W-1:0] ba;
  } rpy_lum_t;

  // Weighted sum 299R + 587G + 114B.
  function automatic logic [SUM_W-1:0] luma_sum(input logic [CHAN_W-1:0] r,
                                                input logic [CHAN_W-1:0] g,
                                                input logic [CHAN_W-1:0] b);
    logic [SUM_W-1:0] pr;
    logic [SUM_W-1:0] pg;
    logic [SUM_W-1:0] pb;
    pr = LUMA_R_W * {{(SUM_W-CHAN_W){1'b0}}, r};
    pg = LUMA_G_W * {{(SUM_W-CHAN_W){1'b0}}, g};
    pb = LUMA_B_W * {{(SUM_W-CHAN_W){1'b0}}, b};
    return pr + pg + pb;
  endfunction

  // Quotient by 1000; callers keep s small enough that it fits 8 bits.
  function automatic logic [CHAN_W-1:0] div1000(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = {{RECIP_W{1'b0}}, s} * {{SUM_W{1'b0}}, RECIP_1000};
    return p[RECIP_SHIFT +: CHAN_W];
  endfunction

endpackage

// File: rtl/rpy_if.sv
// ----------------------------------------------------------------------------
// rpy_in_if / rpy_out_if: valid/ready channels of the RGB pair to YUY2
// converter. A transaction completes when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rpy_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_first;
  logic [7:0] green_first;
  logic [7:0] blue_first;
  logic [7:0] red_second;
  logic [7:0] green_second;
  logic [7:0] blue_second;

  modport source (output valid, red_first, green_first, blue_first,
                  red_second, green_second, blue_second, input ready);
  modport sink   (input valid, red_first, green_first, blue_first,
                  red_second, green_second, blue_second, output ready);
endinterface

interface rpy_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] packed_word;

  modport source (output valid, packed_word, input ready);
  modport sink   (input valid, packed_word, output ready);
endinterface

// File: rtl/rpy_luma.sv
// ----------------------------------------------------------------------------
// rpy_luma: first two pipeline stages. Forms the three weighted sums (both
// pixels and their average), then divides each by 1000 to get luma.
// ----------------------------------------------------------------------------
module rpy_luma (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic [rpy_pkg::CHAN_W-1:0]  r0,
  input  logic [rpy_pkg::CHAN_W-1:0]  g0,
  input  logic [rpy_pkg::CHAN_W-1:0]  b0,
  input  logic [rpy_pkg::CHAN_W-1:0]  r1,
  input  logic [rpy_pkg::CHAN_W-1:0]  g1,
  input  logic [rpy_pkg::CHAN_W-1:0]  b1,
  output logic                        out_vld,
  output rpy_pkg::rpy_lum_t           lum
);
  import rpy_pkg::*;

  logic [CHAN_W:0]   r_pair;
  logic [CHAN_W:0]   g_pair;
  logic [CHAN_W:0]   b_pair;
  logic [CHAN_W-1:0] ra;
  logic [CHAN_W-1:0] ga;
  logic [CHAN_W-1:0] ba;

  logic              s1_vld_r;
  logic [SUM_W-1:0]  s1_sum0_r;
  logic [SUM_W-1:0]  s1_sum1_r;
  logic [SUM_W-1:0]  s1_suma_r;
  logic [CHAN_W-1:0] s1_ra_r;
  logic [CHAN_W-1:0] s1_ba_r;

  logic              s2_vld_r;
  rpy_lum_t          s2_lum_r;

  // Channel averages, halved and truncated.
  assign r_pair = {1'b0, r0} + {1'b0, r1};
  assign g_pair = {1'b0, g0} + {1'b0, g1};
  assign b_pair = {1'b0, b0} + {1'b0, b1};
  assign ra = r_pair[CHAN_W:1];
  assign ga = g_pair[CHAN_W:1];
  assign ba = b_pair[CHAN_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum0_r   <= luma_sum(r0, g0, b0);
      s1_sum1_r   <= luma_sum(r1, g1, b1);
      s1_suma_r   <= luma_sum(ra, ga, ba);
      s1_ra_r     <= ra;
      s1_ba_r     <= ba;
      s2_lum_r.y0 <= div1000(s1_sum0_r);
      s2_lum_r.y1 <= div1000(s1_sum1_r);
      s2_lum_r.yy <= div1000(s1_suma_r);
      s2_lum_r.ra <= s1_ra_r;
      s2_lum_r.ba <= s1_ba_r;
    end
  end

  assign out_vld = s2_vld_r;
  assign lum     = s2_lum_r;

endmodule

// File: rtl/rpy_chroma.sv
// ----------------------------------------------------------------------------
// rpy_chroma: last three pipeline stages. Scales the color differences,
// divides by 1000 toward zero, biases, clamps and packs the YUY2 word.
// ----------------------------------------------------------------------------
module rpy_chroma (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  rpy_pkg::rpy_lum_t           lum,
  output logic                        out_vld,
  output logic [rpy_pkg::WORD_W-1:0]  packed_word
);
  import rpy_pkg::*;

  logic [CHAN_W:0]   cb_diff;
  logic [CHAN_W:0]   cr_diff;
  logic [CHAN_W:0]   cb_abs;
  logic [CHAN_W:0]   cr_abs;

  logic              s3_vld_r;
  logic [SUM_W-1:0]  s3_cb_prod_r;
  logic [SUM_W-1:0]  s3_cr_prod_r;
  logic              s3_cb_neg_r;
  logic              s3_cr_neg_r;
  logic [CHAN_W-1:0] s3_y0_r;
  logic [CHAN_W-1:0] s3_y1_r;

  logic              s4_vld_r;
  logic [CHAN_W-1:0] s4_cb_q_r;
  logic [CHAN_W-1:0] s4_cr_q_r;
  logic              s4_cb_neg_r;
  logic              s4_cr_neg_r;
  logic [CHAN_W-1:0] s4_y0_r;
  logic [CHAN_W-1:0] s4_y1_r;

  logic [9:0]        cb_val;
  logic [9:0]        cr_val;
  logic [CHAN_W-1:0] cb_clip;
  logic [CHAN_W-1:0] cr_clip;

  logic              s5_vld_r;
  logic [WORD_W-1:0] s5_word_r;

  // Work on magnitudes so the divide truncates toward zero.
  assign cb_diff = {1'b0, lum.ba} - {1'b0, lum.yy};
  assign cr_diff = {1'b0, lum.ra} - {1'b0, lum.yy};
  assign cb_abs  = cb_diff[CHAN_W] ? -cb_diff : cb_diff;
  assign cr_abs  = cr_diff[CHAN_W] ? -cr_diff : cr_diff;

  // Bias, then clamp to 0..255 (10-bit two's complement).
  assign cb_val = s4_cb_neg_r ? CHROMA_BIAS - {2'b00, s4_cb_q_r}
                              : CHROMA_BIAS + {2'b00, s4_cb_q_r};
  assign cr_val = s4_cr_neg_r ? CHROMA_BIAS - {2'b00, s4_cr_q_r}
                              : CHROMA_BIAS + {2'b00, s4_cr_q_r};

  always_comb begin
    priority if (cb_val[9]) begin
      cb_clip = '0;
    end else if (cb_val > CHAN_MAX) begin
      cb_clip = '1;
    end else begin
      cb_clip = cb_val[CHAN_W-1:0];
    end
    priority if (cr_val[9]) begin
      cr_clip = '0;
    end else if (cr_val > CHAN_MAX) begin
      cr_clip = '1;
    end else begin
      cr_clip = cr_val[CHAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= in_vld;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cb_prod_r <= CB_GAIN * {{(SUM_W-CHAN_W-1){1'b0}}, cb_abs};
      s3_cr_prod_r <= CR_GAIN * {{(SUM_W-CHAN_W-1){1'b0}}, cr_abs};
      s3_cb_neg_r  <= cb_diff[CHAN_W];
      s3_cr_neg_r  <= cr_diff[CHAN_W];
      s3_y0_r      <= lum.y0;
      s3_y1_r      <= lum.y1;

      s4_cb_q_r    <= div1000(s3_cb_prod_r);
      s4_cr_q_r    <= div1000(s3_cr_prod_r);
      s4_cb_neg_r  <= s3_cb_neg_r;
      s4_cr_neg_r  <= s3_cr_neg_r;
      s4_y0_r      <= s3_y0_r;
      s4_y1_r      <= s3_y1_r;

      s5_word_r    <= {s4_y0_r, cb_clip, s4_y1_r, cr_clip};
    end
  end

  assign out_vld     = s5_vld_r;
  assign packed_word = s5_word_r;

endmodule

// File: rtl/rgb_pair_to_yuy2.sv
// ----------------------------------------------------------------------------
// rgb_pair_to_yuy2: RGB pixel pair to packed BT.601 YUY2 word.
// Takes one pair of adjacent 8-bit RGB pixels per clock cycle while not
// stalled and returns {Y0, Cb, Y1, Cr} through a five-stage pipeline
// (weighted sums, luma divide, chroma scale, chroma divide, bias/clamp/pack).
// Every stage holds when the output register is full and not being taken, so
// in_ch.ready follows out_ch.ready in the same cycle; with the output side
// always ready the block sustains one transaction per cycle.
// ----------------------------------------------------------------------------
module rgb_pair_to_yuy2 (
  input  logic  clk,
  input  logic  rst_n,
  rpy_in_if.sink    in_ch,
  rpy_out_if.source out_ch
);
  import rpy_pkg::*;

  logic     adv;
  logic     lum_vld;
  rpy_lum_t lum;
  logic     out_vld;

  // Advance the whole pipeline unless a finished word is stuck at the output.
  assign adv         = !out_vld || out_ch.ready;
  assign in_ch.ready = adv;

  rpy_luma u_luma (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_ch.valid),
    .r0      (in_ch.red_first),
    .g0      (in_ch.green_first),
    .b0      (in_ch.blue_first),
    .r1      (in_ch.red_second),
    .g1      (in_ch.green_second),
    .b1      (in_ch.blue_second),
    .out_vld (lum_vld),
    .lum     (lum)
  );

  rpy_chroma u_chroma (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_vld      (lum_vld),
    .lum         (lum),
    .out_vld     (out_vld),
    .packed_word (out_ch.packed_word)
  );

  assign out_ch.valid = out_vld;

endmodule

// File: tb/sv/rpy_word_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpy_word_checker: scoreboard for the RGB pair to YUY2 converter.
// Watches both channels, predicts the packed {Y0, Cb, Y1, Cr} word of every
// accepted pixel pair and compares each accepted result with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module rpy_word_checker (
  input  logic clk,
  input  logic rst_n,
  rpy_in_if    in_ch,
  rpy_out_if   out_ch,
  output int   fail_count,
  output int   pending_count
);

  localparam int R_WEIGHT  = 299;
  localparam int G_WEIGHT  = 587;
  localparam int B_WEIGHT  = 114;
  localparam int SCALE     = 1000;
  localparam int CB_SCALE  = 564;
  localparam int CR_SCALE  = 713;
  localparam int BIAS      = 128;
  localparam int CHAN_TOP  = 255;
  localparam int MAX_SHOWN = 10;

  logic [31:0] expected_words[$];
  logic [31:0] want_word;
  int          mismatch_count = 0;
  int          waiting_words  = 0;

  assign fail_count    = mismatch_count;
  assign pending_count = waiting_words;

  function automatic int pixel_luma(input int r, input int g, input int b);
    return (R_WEIGHT * r + G_WEIGHT * g + B_WEIGHT * b) / SCALE;
  endfunction

  // Division truncates toward zero for a negative difference, then clamp.
  function automatic logic [7:0] scaled_chroma(input int diff, input int gain);
    int v;
    v = BIAS + (diff * gain) / SCALE;
    if (v < 0) begin
      v = 0;
    end else if (v > CHAN_TOP) begin
      v = CHAN_TOP;
    end
    return v[7:0];
  endfunction

  function automatic logic [31:0] yuy2_word(input logic [7:0] r0, input logic [7:0] g0,
                                            input logic [7:0] b0, input logic [7:0] r1,
                                            input logic [7:0] g1, input logic [7:0] b1);
    int y0;
    int y1;
    int ra;
    int ga;
    int ba;
    int yy;
    y0 = pixel_luma(int'(r0), int'(g0), int'(b0));
    y1 = pixel_luma(int'(r1), int'(g1), int'(b1));
    ra = (int'(r0) + int'(r1)) / 2;
    ga = (int'(g0) + int'(g1)) / 2;
    ba = (int'(b0) + int'(b1)) / 2;
    yy = pixel_luma(ra, ga, ba);
    return {y0[7:0], scaled_chroma(ba - yy, CB_SCALE), y1[7:0],
            scaled_chroma(ra - yy, CR_SCALE)};
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_words.push_back(yuy2_word(in_ch.red_first, in_ch.green_first,
                                           in_ch.blue_first, in_ch.red_second,
                                           in_ch.green_second, in_ch.blue_second));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          if (mismatch_count < MAX_SHOWN) begin
            $display("%0t: unexpected result transaction, packed_word %h",
                     $realtime, out_ch.packed_word);
          end
          mismatch_count++;
        end else begin
          want_word = expected_words.pop_front();
          if (out_ch.packed_word !== want_word) begin
            if (mismatch_count < MAX_SHOWN) begin
              $display("%0t: packed_word mismatch: expected %h, actual %h",
                       $realtime, want_word, out_ch.packed_word);
            end
            mismatch_count++;
          end
        end
      end
      waiting_words = expected_words.size();
    end
  end

endmodule

// File: tb/sv/tb_rgb_pair_to_yuy2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_pair_to_yuy2: testbench for the RGB pair to YUY2 converter.
// Drives directed corner pairs, then random pairs in four phases: none,
// sender idling, receiver stalling, both; the checker scores every result word.
// ----------------------------------------------------------------------------
module tb_rgb_pair_to_yuy2;

  localparam int RESET_CYCLES = 10;
  localparam int PHASE_PAIRS  = 413;
  localparam int SETTLE       = 20;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  int   cycle_count    = 0;
  int   fail_count;
  int   pending_count;

  rpy_in_if  in_ch ();
  rpy_out_if out_ch ();

  rgb_pair_to_yuy2 DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rpy_word_checker word_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall at random at the current percentage.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Lean toward the channel extremes now and then.
  function automatic logic [7:0] pick_channel();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) begin
      return 8'd0;
    end else if (sel == 1) begin
      return 8'd255;
    end
    return 8'($urandom_range(255));
  endfunction

  // Entered and left at a falling edge; valid stays high after acceptance.
  task automatic send_pair(input logic [7:0] r0, input logic [7:0] g0, input logic [7:0] b0,
                           input logic [7:0] r1, input logic [7:0] g1, input logic [7:0] b1);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.red_first    <= r0;
    in_ch.green_first  <= g0;
    in_ch.blue_first   <= b0;
    in_ch.red_second   <= r1;
    in_ch.green_second <= g1;
    in_ch.blue_second  <= b1;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted word has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.red_first    <= 8'd0;
    in_ch.green_first  <= 8'd0;
    in_ch.blue_first   <= 8'd0;
    in_ch.red_second   <= 8'd0;
    in_ch.green_second <= 8'd0;
    in_ch.blue_second  <= 8'd0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // black, white, primaries, secondaries
    send_pair(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pair(8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0);
    send_pair(8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0);
    send_pair(8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255);
    send_pair(8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0);
    send_pair(8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd255);
    send_pair(8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   8'd255);
    // pixels at opposite extremes: odd channel sums halve with truncation
    send_pair(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0);
    send_pair(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255);
    send_pair(8'd255, 8'd0,   8'd0,   8'd0,   8'd255, 8'd0);
    send_pair(8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 8'd0);
    send_pair(8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0);
    // negative chroma differences truncate toward zero
    send_pair(8'd0,   8'd255, 8'd0,   8'd0,   8'd254, 8'd0);
    send_pair(8'd1,   8'd3,   8'd0,   8'd0,   8'd2,   8'd1);
    send_pair(8'd0,   8'd10,  8'd3,   8'd0,   8'd9,   8'd2);
    send_pair(8'd128, 8'd128, 8'd128, 8'd127, 8'd127, 8'd127);
    send_pair(8'd254, 8'd1,   8'd254, 8'd1,   8'd254, 8'd1);
    send_pair(8'd170, 8'd85,  8'd170, 8'd85,  8'd170, 8'd85);
    send_pair(8'd85,  8'd170, 8'd85,  8'd170, 8'd85,  8'd170);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
        default: begin src_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      for (int n = 0; n < PHASE_PAIRS; n++) begin
        send_pair(pick_channel(), pick_channel(), pick_channel(),
                  pick_channel(), pick_channel(), pick_channel());
      end
      drain_results();
    end

    sink_stall_pct = 0;
    while (pending_count != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
